/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the run tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define USRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define USRT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/usrt_pkg.sv */
// ---------------------------------------------------------------------------
// usrt_pkg
// Types and constants shared by the unit step run tracker.
// ---------------------------------------------------------------------------
package usrt_pkg;

  localparam int OP_W     = 2;
  localparam int REGION_W = 5;
  localparam int WORD_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int RUN_W    = 16;
  localparam int AGE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSV    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT  = 3'd4;

  localparam logic [7:0]  RECORD_MIN_RST = 8'd3;
  localparam logic [14:0] REPORT_MIN_RST = 15'd3;
  localparam logic [14:0] REPORT_MAX_RST = 15'd120;
  localparam logic [7:0]  WINDOW_RST     = 8'd4;
  localparam logic [14:0] RUN_LIMIT_RST  = 15'd32000;

  localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

  typedef struct packed {
    logic                    known;
    logic [VALUE_W-1:0]      last_value;
    logic signed [RUN_W-1:0] run_count;
    logic signed [RUN_W-1:0] recent_run;
    logic [VALUE_W-1:0]      recent_value;
    logic [AGE_W-1:0]        recent_age;
  } entry_t;

endpackage

/* rtl/usrt_in_if.sv */
// ---------------------------------------------------------------------------
// usrt_in_if
// Item channel into the run tracker: operation, entry address and sample.
// ---------------------------------------------------------------------------
interface usrt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [usrt_pkg::OP_W-1:0]              operation;
  logic [usrt_pkg::REGION_W-1:0]          region_index;
  logic [usrt_pkg::WORD_W-1:0]            word_index;
  logic signed [usrt_pkg::VALUE_W-1:0]    sample_value;

  modport source (output valid, operation, region_index, word_index, sample_value,
                  input ready);
  modport sink   (input valid, operation, region_index, word_index, sample_value,
                  output ready);
endinterface

/* rtl/usrt_out_if.sv */
// ---------------------------------------------------------------------------
// usrt_out_if
// Result channel out of the run tracker.
// ---------------------------------------------------------------------------
interface usrt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [usrt_pkg::RUN_W-1:0]    run_length;
  logic signed [usrt_pkg::VALUE_W-1:0]  run_value;
  logic                                 reportable;
  logic                                 from_recent;
  logic                                 entry_known;

  modport source (output valid, run_length, run_value, reportable, from_recent,
                  entry_known, input ready);
  modport sink   (input valid, run_length, run_value, reportable, from_recent,
                  entry_known, output ready);
endinterface

/* rtl/usrt_cfg_if.sv */
// ---------------------------------------------------------------------------
// usrt_cfg_if
// Register write channel of the run tracker.
// ---------------------------------------------------------------------------
interface usrt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [usrt_pkg::CFG_IDX_W-1:0]      index;
  logic [usrt_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/usrt_table.sv */
// ---------------------------------------------------------------------------
// usrt_table
// Entry memory with registered read, write-to-read forwarding and a
// clearing pass after reset that drops the known flag of every entry.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module usrt_table #(
  parameter int ENTRIES = 6144,
  parameter int AW      = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  usrt_pkg::entry_t wr_data,
  output usrt_pkg::entry_t rd_data,
  output logic             busy
);

  usrt_pkg::entry_t mem [ENTRIES];
  usrt_pkg::entry_t rd_q;
  usrt_pkg::entry_t fwd_q;
  logic             fwd_hit;
  logic [AW-1:0]    clr_addr;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  usrt_pkg::entry_t mem_wd;

  assign mem_we = busy | wr_en;
  assign mem_wa = busy ? clr_addr : wr_addr;
  assign mem_wd = busy ? usrt_pkg::entry_t'('0) : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Take the write data when the read of the same entry races it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= mem_we && (mem_wa == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_q <= mem_wd;
    end
  end

  assign rd_data = fwd_hit ? fwd_q : rd_q;

  `USRT_ASSERT(a_fwd_from_write, clk, rst, $rose(fwd_hit) |-> $past(mem_we && rd_en), "forward without write")
  `USRT_ASSERT(a_clear_full_sweep, clk, rst, $fell(busy) |-> ($past(clr_addr) == AW'(ENTRIES - 1)), "clearing pass cut short")
  `USRT_ASSERT(a_no_item_write_in_clear, clk, rst, busy |-> !(wr_en || rd_en), "item access during clearing pass")

endmodule

/* rtl/unit_step_run_tracker_top.sv */
// ---------------------------------------------------------------------------
// unit_step_run_tracker_top
// Tracks runs of +1 / -1 steps per watched word, held in one entry memory.
// ---------------------------------------------------------------------------
// Channels: samples takes an operation (sample, query, clear) with region,
// word and sample value; results returns exactly one transaction per item;
// cfg writes the five control registers and is always ready.
// Flow: the memory read is registered when an item is taken, and the update
// lands in the result register when the update stage advances. Throughput is
// one item per cycle while results.ready stays high: the read of the next
// item overlaps the write back of the current one, and a write to the same
// entry is forwarded to the read.
// Reset: registers return to their defaults and a clearing pass walks the
// memory one entry a cycle over all REGIONS * WORDS_PER_REGION entries (6144
// by default); samples.ready stays low until it ends.
// Stall: while a result waits and results.ready is low the result register
// holds; the update stage takes at most one more item and holds it, and
// samples.ready then stays low until the waiting result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module unit_step_run_tracker_top #(
  parameter int REGIONS          = 24,
  parameter int WORDS_PER_REGION = 256
) (
  input  logic           clk,
  input  logic           rst,
  usrt_in_if.sink        samples,
  usrt_out_if.source     results,
  usrt_cfg_if.sink       cfg
);

  localparam int ENTRIES = REGIONS * WORDS_PER_REGION;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Control registers.
  logic [7:0]  record_min;
  logic [14:0] report_min;
  logic [14:0] report_max;
  logic [7:0]  window;
  logic [14:0] run_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_min <= usrt_pkg::RECORD_MIN_RST;
      report_min <= usrt_pkg::REPORT_MIN_RST;
      report_max <= usrt_pkg::REPORT_MAX_RST;
      window     <= usrt_pkg::WINDOW_RST;
      run_limit  <= usrt_pkg::RUN_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        usrt_pkg::CFG_RECORD_MIN: record_min <= cfg.data[7:0];
        usrt_pkg::CFG_REPORT_MIN: report_min <= cfg.data;
        usrt_pkg::CFG_REPORT_MAX: report_max <= cfg.data;
        usrt_pkg::CFG_WINDOW:     window     <= cfg.data[7:0];
        usrt_pkg::CFG_RUN_LIMIT:  run_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic busy;
  logic accept;
  logic advance;
  logic s1_valid;
  logic out_valid;

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !busy && (!s1_valid || advance);
  assign accept        = samples.valid && samples.ready;
  assign results.valid = out_valid;

  logic [AW-1:0] in_addr;
  logic          in_ok;

  assign in_addr = AW'(32'(samples.region_index) * WORDS_PER_REGION
                       + 32'(samples.word_index));
  assign in_ok   = (32'(samples.region_index) < 32'(REGIONS))
                && (32'(samples.word_index) < 32'(WORDS_PER_REGION));

  logic [usrt_pkg::OP_W-1:0]    s1_op;
  logic                         s1_ok;
  logic [AW-1:0]                s1_addr;
  logic [usrt_pkg::VALUE_W-1:0] s1_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= samples.operation;
      s1_ok    <= in_ok;
      s1_addr  <= in_addr;
      s1_value <= samples.sample_value;
    end
  end

  // Entry memory.
  usrt_pkg::entry_t cur;
  usrt_pkg::entry_t upd;
  logic             tbl_we;

  usrt_table #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .wr_en   (tbl_we),
    .wr_addr (s1_addr),
    .wr_data (upd),
    .rd_data (cur),
    .busy    (busy)
  );

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  // Update stage.
  logic                         act;
  logic                         known;
  logic signed [32:0]           diff;
  logic                         step_up;
  logic                         step_dn;
  logic                         extend;
  logic signed [16:0]           old_x;
  logic signed [16:0]           lim_x;
  logic signed [16:0]           step_n;
  logic signed [15:0]           new_run;
  logic [15:0]                  old_mag;
  logic [15:0]                  cur_mag;
  logic [15:0]                  rec_mag;
  logic [15:0]                  len;
  logic                         pick_recent;
  logic signed [15:0]           q_run;
  logic [usrt_pkg::VALUE_W-1:0] q_value;

  logic signed [15:0]           res_run;
  logic [usrt_pkg::VALUE_W-1:0] res_value;
  logic                         res_rep;
  logic                         res_rec;
  logic                         res_known;

  assign act   = s1_ok && (s1_op != usrt_pkg::OP_RSV);
  assign known = act && cur.known;

  always_comb begin
    diff    = {s1_value[31], s1_value} - {cur.last_value[31], cur.last_value};
    step_up = (diff == 33'sd1);
    step_dn = (diff == -33'sd1);
    old_x   = {cur.run_count[15], cur.run_count};
    lim_x   = {2'b00, run_limit};
    extend  = (step_up && !cur.run_count[15]) || (step_dn && (old_x <= 17'sd0));
    step_n  = step_up ? (old_x + 17'sd1) : (old_x - 17'sd1);
    if (step_n > lim_x) begin
      step_n = lim_x;
    end
    if (step_n < -lim_x) begin
      step_n = -lim_x;
    end
    new_run = step_n[15:0];
    old_mag = mag16(cur.run_count);
    cur_mag = old_mag;
    rec_mag = mag16(cur.recent_run);
    pick_recent = (cur.recent_age <= window) && (rec_mag > cur_mag);
    q_run   = pick_recent ? cur.recent_run : cur.run_count;
    q_value = pick_recent ? cur.recent_value : cur.last_value;
    len     = pick_recent ? rec_mag : cur_mag;
  end

  always_comb begin
    upd       = cur;
    tbl_we    = 1'b0;
    res_run   = '0;
    res_value = '0;
    res_rep   = 1'b0;
    res_rec   = 1'b0;
    res_known = known;
    case (s1_op)
      usrt_pkg::OP_SAMPLE: begin
        if (act) begin
          tbl_we = advance;
          if (!cur.known) begin
            upd.known        = 1'b1;
            upd.last_value   = s1_value;
            upd.run_count    = '0;
            upd.recent_run   = '0;
            upd.recent_value = '0;
            upd.recent_age   = usrt_pkg::AGE_MAX;
          end else begin
            upd.last_value = s1_value;
            if (cur.recent_age != usrt_pkg::AGE_MAX) begin
              upd.recent_age = cur.recent_age + 8'd1;
            end
            if (extend) begin
              upd.run_count = new_run;
            end else begin
              upd.run_count = '0;
              if (old_mag >= {8'd0, record_min}) begin
                upd.recent_run   = cur.run_count;
                upd.recent_value = cur.last_value;
                upd.recent_age   = '0;
              end
            end
          end
          res_run   = upd.run_count;
          res_value = s1_value;
        end
      end
      usrt_pkg::OP_QUERY: begin
        if (known) begin
          res_run   = q_run;
          res_value = q_value;
          res_rec   = pick_recent;
          res_rep   = (len >= {1'b0, report_min}) && (len <= {1'b0, report_max});
        end
      end
      usrt_pkg::OP_CLEAR: begin
        if (act) begin
          tbl_we    = advance;
          upd.known = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.run_length  <= res_run;
      results.run_value   <= res_value;
      results.reportable  <= res_rep;
      results.from_recent <= res_rec;
      results.entry_known <= res_known;
    end
  end

  `USRT_ASSERT(a_busy_blocks_input, clk, rst, busy |-> !samples.ready, "item taken during clearing pass")
  `USRT_ASSERT(a_advance_loads_result, clk, rst, advance |=> results.valid, "result lost on advance")
  `USRT_ASSERT(a_write_needs_item, clk, rst, tbl_we |-> (s1_valid && advance), "entry write without item")
  `USRT_ASSERT(a_stall_holds_item, clk, rst, (s1_valid && !advance) |=> s1_valid, "stalled item dropped")

endmodule
